>>> sv/vgm_pkg.sv
// Shared constants, codes and types of the voxel greedy mesher.
package vgm_pkg;

    localparam int EDGE_CELLS = 8;
    localparam int EB         = $clog2(EDGE_CELLS);
    localparam int SDEPTH     = EDGE_CELLS * EDGE_CELLS * EDGE_CELLS;
    localparam int SAW        = $clog2(SDEPTH);
    localparam int MDEPTH     = EDGE_CELLS * EDGE_CELLS;
    localparam int MAW        = $clog2(MDEPTH);
    localparam int WW         = $clog2(EDGE_CELLS + 1);

    localparam int IN_DW  = 32;
    localparam int OUT_DW = 120;
    localparam int CFG_DW = 31;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_MESH  = 2'd2;

    localparam logic [1:0] KIND_QUAD  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic [1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] REG_ORIGIN_Z = 2'd2;

    typedef logic [4:0] dp_cmd_t;

    localparam dp_cmd_t CMD_NONE     = 5'd0;
    localparam dp_cmd_t CMD_CLR      = 5'd1;
    localparam dp_cmd_t CMD_ACCEPT   = 5'd2;
    localparam dp_cmd_t CMD_WRITE    = 5'd3;
    localparam dp_cmd_t CMD_RD_ISSUE = 5'd4;
    localparam dp_cmd_t CMD_RD_OUT   = 5'd5;
    localparam dp_cmd_t CMD_B_A      = 5'd6;
    localparam dp_cmd_t CMD_B_B      = 5'd7;
    localparam dp_cmd_t CMD_B_W      = 5'd8;
    localparam dp_cmd_t CMD_S_RD     = 5'd9;
    localparam dp_cmd_t CMD_S_T      = 5'd10;
    localparam dp_cmd_t CMD_SKIP     = 5'd11;
    localparam dp_cmd_t CMD_W_RD     = 5'd12;
    localparam dp_cmd_t CMD_W_INC    = 5'd13;
    localparam dp_cmd_t CMD_H_RD     = 5'd14;
    localparam dp_cmd_t CMD_K_INC    = 5'd15;
    localparam dp_cmd_t CMD_H_INC    = 5'd16;
    localparam dp_cmd_t CMD_CLR_INIT = 5'd17;
    localparam dp_cmd_t CMD_MCLR     = 5'd18;
    localparam dp_cmd_t CMD_EMIT     = 5'd19;
    localparam dp_cmd_t CMD_FIN      = 5'd20;

    typedef struct packed {
        logic       clr_last;
        logic       out_free;
        logic       pend_valid;
        logic [1:0] op;
        logic       axis_none;
        logic       i_last;
        logic       j_last;
        logic       rd_zero;
        logic       rd_match;
        logic       w_more;
        logic       h_more;
        logic       k_last;
        logic       l_last;
        logic       row_done;
    } dp_status_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] corner_x;
        logic [31:0] corner_y;
        logic [31:0] corner_z;
        logic [3:0]  quad_width;
        logic [3:0]  quad_height;
        logic        facing_negative;
        logic [7:0]  block_value;
        logic        last;
    } result_t;

endpackage

>>> sv/vgm_ctrl.sv
// Controller state machine of the voxel greedy mesher.
module vgm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  vgm_pkg::dp_status_t status,
    output vgm_pkg::dp_cmd_t    cmd
);

    localparam logic [4:0] ST_CLEAR    = 5'd0;
    localparam logic [4:0] ST_IDLE     = 5'd1;
    localparam logic [4:0] ST_DISPATCH = 5'd2;
    localparam logic [4:0] ST_WRITE    = 5'd3;
    localparam logic [4:0] ST_RD_ISSUE = 5'd4;
    localparam logic [4:0] ST_RD_OUT   = 5'd5;
    localparam logic [4:0] ST_B_A      = 5'd6;
    localparam logic [4:0] ST_B_B      = 5'd7;
    localparam logic [4:0] ST_B_W      = 5'd8;
    localparam logic [4:0] ST_S_RD     = 5'd9;
    localparam logic [4:0] ST_S_T      = 5'd10;
    localparam logic [4:0] ST_W_RD     = 5'd11;
    localparam logic [4:0] ST_W_CHK    = 5'd12;
    localparam logic [4:0] ST_H_RD     = 5'd13;
    localparam logic [4:0] ST_H_CHK    = 5'd14;
    localparam logic [4:0] ST_CLR_INIT = 5'd15;
    localparam logic [4:0] ST_MCLR     = 5'd16;
    localparam logic [4:0] ST_EMIT     = 5'd17;
    localparam logic [4:0] ST_FIN      = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = vgm_pkg::CMD_NONE;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd = vgm_pkg::CMD_CLR;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd        = vgm_pkg::CMD_ACCEPT;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.op)
                    vgm_pkg::OP_WRITE: state_next = ST_WRITE;
                    vgm_pkg::OP_READ:  state_next = ST_RD_ISSUE;
                    vgm_pkg::OP_MESH:  state_next = status.axis_none ? ST_FIN : ST_B_A;
                    default:           state_next = ST_IDLE;
                endcase
            end
            ST_WRITE:
            begin
                cmd        = vgm_pkg::CMD_WRITE;
                state_next = ST_IDLE;
            end
            ST_RD_ISSUE:
            begin
                cmd        = vgm_pkg::CMD_RD_ISSUE;
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                if (status.out_free)
                begin
                    cmd        = vgm_pkg::CMD_RD_OUT;
                    state_next = ST_IDLE;
                end
            end
            ST_B_A:
            begin
                cmd        = vgm_pkg::CMD_B_A;
                state_next = ST_B_B;
            end
            ST_B_B:
            begin
                cmd        = vgm_pkg::CMD_B_B;
                state_next = ST_B_W;
            end
            ST_B_W:
            begin
                cmd        = vgm_pkg::CMD_B_W;
                state_next = (status.i_last && status.j_last) ? ST_S_RD : ST_B_A;
            end
            ST_S_RD:
            begin
                cmd        = vgm_pkg::CMD_S_RD;
                state_next = ST_S_T;
            end
            ST_S_T:
            begin
                if (status.rd_zero)
                begin
                    cmd        = vgm_pkg::CMD_SKIP;
                    state_next = (status.i_last && status.j_last) ? ST_FIN : ST_S_RD;
                end
                else
                begin
                    cmd        = vgm_pkg::CMD_S_T;
                    state_next = ST_W_RD;
                end
            end
            ST_W_RD:
            begin
                if (status.w_more)
                begin
                    cmd        = vgm_pkg::CMD_W_RD;
                    state_next = ST_W_CHK;
                end
                else
                begin
                    state_next = ST_H_RD;
                end
            end
            ST_W_CHK:
            begin
                if (status.rd_match)
                begin
                    cmd        = vgm_pkg::CMD_W_INC;
                    state_next = ST_W_RD;
                end
                else
                begin
                    state_next = ST_H_RD;
                end
            end
            ST_H_RD:
            begin
                if (status.h_more)
                begin
                    cmd        = vgm_pkg::CMD_H_RD;
                    state_next = ST_H_CHK;
                end
                else
                begin
                    state_next = ST_CLR_INIT;
                end
            end
            ST_H_CHK:
            begin
                if (!status.rd_match)
                begin
                    state_next = ST_CLR_INIT;
                end
                else if (status.k_last)
                begin
                    cmd        = vgm_pkg::CMD_H_INC;
                    state_next = ST_H_RD;
                end
                else
                begin
                    cmd        = vgm_pkg::CMD_K_INC;
                    state_next = ST_H_RD;
                end
            end
            ST_CLR_INIT:
            begin
                cmd        = vgm_pkg::CMD_CLR_INIT;
                state_next = ST_MCLR;
            end
            ST_MCLR:
            begin
                cmd = vgm_pkg::CMD_MCLR;
                if (status.k_last && status.l_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // A held quad can only move on once the output register is free.
                if (!status.pend_valid || status.out_free)
                begin
                    cmd = vgm_pkg::CMD_EMIT;
                    state_next = (status.row_done && status.j_last) ? ST_FIN : ST_S_RD;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd        = vgm_pkg::CMD_FIN;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/vgm_datapath.sv
// Datapath of the voxel greedy mesher: block store, face mask, counters and result registers.
module vgm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vgm_pkg::dp_cmd_t              cmd,
    output vgm_pkg::dp_status_t           status,
    input  logic [vgm_pkg::IN_DW-1:0]     s_tdata,
    input  logic [1:0]                    s_tuser,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [vgm_pkg::CFG_DW-1:0]    cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vgm_pkg::OUT_DW-1:0]    m_tdata,
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);

    localparam int E  = vgm_pkg::EDGE_CELLS;
    localparam int RW = $bits(vgm_pkg::result_t);

    logic [7:0] store_mem [vgm_pkg::SDEPTH];
    logic [8:0] mask_mem  [vgm_pkg::MDEPTH];

    logic [vgm_pkg::SAW-1:0]    clr_cnt_reg;
    logic                       out_valid_reg;
    logic                       pend_valid_reg;
    logic [vgm_pkg::CFG_DW-1:0] org_x_reg, org_y_reg, org_z_reg;
    vgm_pkg::result_t           out_reg, pend_reg, quad_new;

    logic [1:0]        op_reg, axis_reg;
    logic [3:0]        cx_reg, cy_reg, cz_reg, plane_reg;
    logic [7:0]        nb_reg, store_rd_reg, a_reg;
    logic [8:0]        mask_rd_reg, t_reg, mask_new;
    logic              ina_reg, inb_reg;
    logic [vgm_pkg::EB-1:0] i_reg, j_reg, k_reg, l_reg;
    logic [vgm_pkg::WW-1:0] w_reg, h_reg;

    logic                    cell_inside, d_inside, out_load;
    logic [3:0]              d_coord;
    logic [vgm_pkg::EB-1:0]  bx, by, bz, d_low, i_next, j_next;
    logic [vgm_pkg::SAW-1:0] s_addr, b_addr, st_waddr, st_raddr;
    logic [vgm_pkg::MAW-1:0] m_raddr, m_waddr;
    logic                    st_we, st_re, m_we, m_re;
    logic [7:0]              st_wdata, b_val;
    logic [31:0]             lx, ly, lz;

    function automatic logic [vgm_pkg::MAW-1:0] mask_addr(input int row, input int col);
        mask_addr = vgm_pkg::MAW'(row * vgm_pkg::EDGE_CELLS + col);
    endfunction

    // Addresses of the latched cell and of the cell compared during the mask build.
    assign cell_inside = (int'(cx_reg) < E) && (int'(cy_reg) < E) && (int'(cz_reg) < E);
    assign s_addr = vgm_pkg::SAW'((int'(cx_reg) * E + int'(cy_reg)) * E + int'(cz_reg));

    assign d_coord  = (cmd == vgm_pkg::CMD_B_A) ? (plane_reg - 4'd1) : plane_reg;
    assign d_inside = (cmd == vgm_pkg::CMD_B_A) ? ((plane_reg != 4'd0) && (int'(plane_reg) <= E))
                                                : (int'(plane_reg) < E);
    assign d_low    = d_coord[vgm_pkg::EB-1:0];

    always_comb
    begin
        case (axis_reg)
            vgm_pkg::AXIS_X:
            begin
                bx = d_low; by = i_reg; bz = j_reg;
                lx = 32'(plane_reg); ly = 32'(i_reg); lz = 32'(j_reg);
            end
            vgm_pkg::AXIS_Y:
            begin
                bx = j_reg; by = d_low; bz = i_reg;
                lx = 32'(j_reg); ly = 32'(plane_reg); lz = 32'(i_reg);
            end
            default:
            begin
                bx = i_reg; by = j_reg; bz = d_low;
                lx = 32'(i_reg); ly = 32'(j_reg); lz = 32'(plane_reg);
            end
        endcase
    end

    assign b_addr = vgm_pkg::SAW'((int'(bx) * E + int'(by)) * E + int'(bz));
    assign b_val  = inb_reg ? store_rd_reg : 8'd0;

    always_comb
    begin
        if ((a_reg != 8'd0) == (b_val != 8'd0))
        begin
            mask_new = 9'd0;
        end
        else if (a_reg != 8'd0)
        begin
            mask_new = {1'b0, a_reg};
        end
        else
        begin
            mask_new = {1'b1, b_val};
        end
    end

    // Block store port selection.
    assign st_we    = (cmd == vgm_pkg::CMD_CLR) || ((cmd == vgm_pkg::CMD_WRITE) && cell_inside);
    assign st_waddr = (cmd == vgm_pkg::CMD_CLR) ? clr_cnt_reg : s_addr;
    assign st_wdata = (cmd == vgm_pkg::CMD_CLR) ? 8'd0 : nb_reg;
    assign st_re    = (cmd == vgm_pkg::CMD_RD_ISSUE) || (cmd == vgm_pkg::CMD_B_A) ||
                      (cmd == vgm_pkg::CMD_B_B);
    assign st_raddr = (cmd == vgm_pkg::CMD_RD_ISSUE) ? s_addr : b_addr;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= st_wdata;
        end
        if (st_re)
        begin
            store_rd_reg <= store_mem[st_raddr];
        end
    end

    // Face mask port selection.
    assign m_we    = (cmd == vgm_pkg::CMD_B_W) || (cmd == vgm_pkg::CMD_MCLR);
    assign m_waddr = (cmd == vgm_pkg::CMD_B_W) ? mask_addr(int'(j_reg), int'(i_reg))
                                                : mask_addr(int'(j_reg) + int'(l_reg),
                                                            int'(i_reg) + int'(k_reg));
    assign m_re    = (cmd == vgm_pkg::CMD_S_RD) || (cmd == vgm_pkg::CMD_W_RD) ||
                     (cmd == vgm_pkg::CMD_H_RD);

    always_comb
    begin
        case (cmd)
            vgm_pkg::CMD_W_RD: m_raddr = mask_addr(int'(j_reg), int'(i_reg) + int'(w_reg));
            vgm_pkg::CMD_H_RD: m_raddr = mask_addr(int'(j_reg) + int'(h_reg),
                                                   int'(i_reg) + int'(k_reg));
            default:           m_raddr = mask_addr(int'(j_reg), int'(i_reg));
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            mask_mem[m_waddr] <= (cmd == vgm_pkg::CMD_B_W) ? mask_new : 9'd0;
        end
        if (m_re)
        begin
            mask_rd_reg <= mask_mem[m_raddr];
        end
    end

    // Raster advance over the plane, also used after a merged quad.
    assign j_next = status.j_last ? '0 : vgm_pkg::EB'(int'(j_reg) + 1);
    assign i_next = status.i_last ? '0 : vgm_pkg::EB'(int'(i_reg) + 1);

    assign status.clr_last   = (int'(clr_cnt_reg) == vgm_pkg::SDEPTH - 1);
    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.pend_valid = pend_valid_reg;
    assign status.op         = op_reg;
    assign status.axis_none  = (axis_reg == vgm_pkg::AXIS_NONE);
    assign status.i_last     = (int'(i_reg) == E - 1);
    assign status.j_last     = (int'(j_reg) == E - 1);
    assign status.rd_zero    = (mask_rd_reg == 9'd0);
    assign status.rd_match   = (mask_rd_reg == t_reg);
    assign status.w_more     = (int'(i_reg) + int'(w_reg) < E);
    assign status.h_more     = (int'(j_reg) + int'(h_reg) < E);
    assign status.k_last     = (int'(k_reg) == int'(w_reg) - 1);
    assign status.l_last     = (int'(l_reg) == int'(h_reg) - 1);
    assign status.row_done   = (int'(i_reg) + int'(w_reg) >= E);

    always_comb
    begin
        quad_new.kind            = vgm_pkg::KIND_QUAD;
        quad_new.corner_x        = {org_x_reg[vgm_pkg::CFG_DW-1], org_x_reg} + lx;
        quad_new.corner_y        = {org_y_reg[vgm_pkg::CFG_DW-1], org_y_reg} + ly;
        quad_new.corner_z        = {org_z_reg[vgm_pkg::CFG_DW-1], org_z_reg} + lz;
        quad_new.quad_width      = 4'(w_reg);
        quad_new.quad_height     = 4'(h_reg);
        quad_new.facing_negative = t_reg[8];
        quad_new.block_value     = t_reg[7:0];
        quad_new.last            = 1'b0;
    end

    assign out_load = (cmd == vgm_pkg::CMD_RD_OUT) || (cmd == vgm_pkg::CMD_FIN) ||
                      ((cmd == vgm_pkg::CMD_EMIT) && pend_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            org_x_reg      <= '0;
            org_y_reg      <= '0;
            org_z_reg      <= '0;
        end
        else
        begin
            if (cmd == vgm_pkg::CMD_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((cmd == vgm_pkg::CMD_ACCEPT) || (cmd == vgm_pkg::CMD_FIN))
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd == vgm_pkg::CMD_EMIT)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    vgm_pkg::REG_ORIGIN_X: org_x_reg <= cfg_data;
                    vgm_pkg::REG_ORIGIN_Y: org_y_reg <= cfg_data;
                    vgm_pkg::REG_ORIGIN_Z: org_z_reg <= cfg_data;
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            vgm_pkg::CMD_ACCEPT:
            begin
                op_reg    <= s_tuser;
                cx_reg    <= s_tdata[3:0];
                cy_reg    <= s_tdata[7:4];
                cz_reg    <= s_tdata[11:8];
                nb_reg    <= s_tdata[19:12];
                axis_reg  <= s_tdata[21:20];
                plane_reg <= s_tdata[25:22];
                i_reg     <= '0;
                j_reg     <= '0;
            end
            vgm_pkg::CMD_RD_OUT:
            begin
                // Kind, zero corners and extents, the id and the last flag.
                out_reg <= {vgm_pkg::KIND_READ, 105'd0,
                            (cell_inside ? store_rd_reg : 8'd0), 1'b1};
            end
            vgm_pkg::CMD_B_A:
            begin
                ina_reg <= d_inside;
            end
            vgm_pkg::CMD_B_B:
            begin
                a_reg   <= ina_reg ? store_rd_reg : 8'd0;
                inb_reg <= d_inside;
            end
            vgm_pkg::CMD_B_W, vgm_pkg::CMD_SKIP:
            begin
                i_reg <= i_next;
                if (status.i_last)
                begin
                    j_reg <= j_next;
                end
            end
            vgm_pkg::CMD_S_T:
            begin
                t_reg <= mask_rd_reg;
                w_reg <= vgm_pkg::WW'(1);
                h_reg <= vgm_pkg::WW'(1);
                k_reg <= '0;
            end
            vgm_pkg::CMD_W_INC:
            begin
                w_reg <= w_reg + 1'b1;
            end
            vgm_pkg::CMD_K_INC:
            begin
                k_reg <= k_reg + 1'b1;
            end
            vgm_pkg::CMD_H_INC:
            begin
                h_reg <= h_reg + 1'b1;
                k_reg <= '0;
            end
            vgm_pkg::CMD_CLR_INIT:
            begin
                k_reg <= '0;
                l_reg <= '0;
            end
            vgm_pkg::CMD_MCLR:
            begin
                if (status.k_last)
                begin
                    k_reg <= '0;
                    l_reg <= l_reg + 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            vgm_pkg::CMD_EMIT:
            begin
                // The previous quad leaves only now, when it is known not to be the last.
                if (pend_valid_reg)
                begin
                    out_reg <= pend_reg;
                end
                pend_reg <= quad_new;
                if (status.row_done)
                begin
                    i_reg <= '0;
                    j_reg <= j_next;
                end
                else
                begin
                    i_reg <= vgm_pkg::EB'(int'(i_reg) + int'(w_reg));
                end
            end
            vgm_pkg::CMD_FIN:
            begin
                if (pend_valid_reg)
                begin
                    out_reg <= {pend_reg[RW-1:1], 1'b1};
                end
                else
                begin
                    out_reg <= {vgm_pkg::KIND_EMPTY, 113'd0, 1'b1};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'd0, out_reg.block_value, out_reg.facing_negative,
                       out_reg.quad_height, out_reg.quad_width,
                       out_reg.corner_z, out_reg.corner_y, out_reg.corner_x};

endmodule

>>> sv/voxel_greedy_mesher_unit.sv
// A write passes through the dispatch and write states before the input is free again; a read passes
// through dispatch, read issue and read output, where it waits for a free output register. A mesh first
// builds the face mask, reading two store cells per entry through the store's one read port, then skips
// each empty mask entry and, per merged rectangle, probes width, then height, clears the covered entries.
// One item at a time; the output register lets the next item start while a result waits.
// After reset the 512-entry block store is cleared, during which s_tready is low.
module voxel_greedy_mesher_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cell_x[3:0], cell_y[7:4], cell_z[11:8], new_block[19:12], axis[21:20], plane[25:22]
    input  logic [vgm_pkg::IN_DW-1:0]     s_tdata,
    // opcode[1:0]
    input  logic [1:0]                    s_tuser,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [vgm_pkg::CFG_DW-1:0]    cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // corner_x[31:0], corner_y[63:32], corner_z[95:64], quad_width[99:96],
    // quad_height[103:100], facing_negative[104], block_value[112:105]
    output logic [vgm_pkg::OUT_DW-1:0]    m_tdata,
    // result_kind[1:0]
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);

    vgm_pkg::dp_cmd_t    cmd;
    vgm_pkg::dp_status_t status;

    vgm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vgm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> sv/vgm_checker.sv
// Port-level assertions for the voxel greedy mesher and their binding.
module vgm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [vgm_pkg::OUT_DW-1:0]    m_tdata,
    input logic [1:0]                    m_tuser,
    input logic                          m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // A read answer is a single transaction carrying only the block id.
    a_read_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == vgm_pkg::KIND_READ) |-> m_tlast && (m_tdata[104:0] == '0))
        else $error("malformed read result");

    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == vgm_pkg::KIND_EMPTY) |-> m_tlast && (m_tdata == '0))
        else $error("malformed empty plane marker");

    // Every quad covers at least one face of a solid block.
    a_quad_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == vgm_pkg::KIND_QUAD) |->
            (m_tdata[99:96] != 4'd0) && (m_tdata[103:100] != 4'd0) &&
            (m_tdata[112:105] != 8'd0))
        else $error("quad with empty extent or air id");

endmodule

bind voxel_greedy_mesher_unit vgm_checker u_vgm_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for the voxel greedy mesher: directed and random commands.
`timescale 1ns / 100ps

module tb_top;

    localparam int EC = vgm_pkg::EDGE_CELLS;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [3:0]  w;
        logic [3:0]  h;
        logic        neg;
        logic [7:0]  val;
        logic        last;
    } quad_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [vgm_pkg::IN_DW-1:0] s_tdata;
    logic [1:0] s_tuser;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [vgm_pkg::CFG_DW-1:0] cfg_data;
    logic m_tvalid;
    logic m_tready;
    logic [vgm_pkg::OUT_DW-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;

    voxel_greedy_mesher_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // Shadow copy of the chunk and origin registers.
    logic [7:0]  chunk [0:vgm_pkg::SDEPTH-1];
    logic [31:0] org [0:2];
    logic [8:0]  faces [0:vgm_pkg::MDEPTH-1];
    quad_t       pending_quads[$];
    int          errors;
    int          send_idle;
    int          recv_idle;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [7:0] cell_val(int c0, int c1, int c2);
        if (c0 < 0 || c0 >= EC || c1 < 0 || c1 >= EC || c2 < 0 || c2 >= EC)
            return 8'd0;
        return chunk[(c0 * EC + c1) * EC + c2];
    endfunction

    function automatic quad_t mk(logic [1:0] k, logic [31:0] x, logic [31:0] y,
                                 logic [31:0] z, int w, int h, logic n, logic [7:0] v);
        quad_t q;
        q.kind = k; q.cx = x; q.cy = y; q.cz = z;
        q.w = w[3:0]; q.h = h[3:0]; q.neg = n; q.val = v; q.last = 1'b0;
        return q;
    endfunction

    task automatic expect_result(quad_t q);
        pending_quads.insert(pending_quads.size(), q);
    endtask

    task automatic mesh_plane_predict(int d, int p);
        int u, v, i, j, w, h, k, l, n;
        int c [0:2];
        logic [7:0] a, b;
        logic [8:0] t;
        logic ok;
        u = (d + 1) % 3;
        v = (d + 2) % 3;
        for (j = 0; j < EC; j++)
            for (i = 0; i < EC; i++)
            begin
                c[u] = i; c[v] = j;
                c[d] = p - 1; a = cell_val(c[0], c[1], c[2]);
                c[d] = p;     b = cell_val(c[0], c[1], c[2]);
                if ((a != 0) == (b != 0)) faces[j * EC + i] = 9'd0;
                else if (a != 0)         faces[j * EC + i] = {1'b0, a};
                else                     faces[j * EC + i] = {1'b1, b};
            end
        for (j = 0; j < EC; j++)
        begin
            i = 0;
            while (i < EC)
            begin
                n = j * EC + i;
                t = faces[n];
                if (t == 0)
                begin
                    i++;
                    continue;
                end
                for (w = 1; i + w < EC && faces[n + w] == t; w++) ;
                for (h = 1; j + h < EC; h++)
                begin
                    ok = 1'b1;
                    for (k = 0; k < w; k++)
                        if (faces[n + k + h * EC] != t) ok = 1'b0;
                    if (!ok) break;
                end
                for (l = 0; l < h; l++)
                    for (k = 0; k < w; k++)
                        faces[n + k + l * EC] = 9'd0;
                c[d] = p; c[u] = i; c[v] = j;
                expect_result(mk(vgm_pkg::KIND_QUAD, org[0] + c[0], org[1] + c[1],
                                 org[2] + c[2], w, h, t[8], t[7:0]));
                i += w;
            end
        end
    endtask

    // Works out the results of one command and queues them.
    task automatic predict_command(logic [1:0] op, logic [3:0] x, logic [3:0] y,
                                   logic [3:0] z, logic [7:0] nb, logic [1:0] ax,
                                   logic [3:0] pl);
        int before_cnt;
        logic in_chunk;
        in_chunk = x < EC && y < EC && z < EC;
        before_cnt = pending_quads.size();
        if (op == vgm_pkg::OP_WRITE)
        begin
            if (in_chunk) chunk[(x * EC + y) * EC + z] = nb;
        end
        else if (op == vgm_pkg::OP_READ)
        begin
            expect_result(mk(vgm_pkg::KIND_READ, 0, 0, 0, 0, 0, 1'b0,
                in_chunk ? chunk[(x * EC + y) * EC + z] : 8'd0));
            pending_quads[$].last = 1'b1;
        end
        else if (op == vgm_pkg::OP_MESH)
        begin
            if (ax != vgm_pkg::AXIS_NONE) mesh_plane_predict(ax, pl);
            if (pending_quads.size() == before_cnt)
                expect_result(mk(vgm_pkg::KIND_EMPTY, 0, 0, 0, 0, 0, 1'b0, 8'd0));
            pending_quads[$].last = 1'b1;
        end
    endtask

    // Leaves tvalid high after the transaction; the next call replaces or lowers it, or wait_drained lowers it.
    task automatic send_command(logic [1:0] op, logic [3:0] x, logic [3:0] y,
                                logic [3:0] z, logic [7:0] nb, logic [1:0] ax,
                                logic [3:0] pl);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        predict_command(op, x, y, z, nb, ax, pl);
        s_tdata  <= {6'd0, pl, ax, nb, z, y, x};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_quads.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_origin(logic [1:0] idx, logic [30:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        org[idx] = {val[30], val};
    endtask

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        quad_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_quads.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d data %h", $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                e = pending_quads.pop_front();
                if (m_tuser !== e.kind || m_tdata[31:0] !== e.cx ||
                    m_tdata[63:32] !== e.cy || m_tdata[95:64] !== e.cz ||
                    m_tdata[99:96] !== e.w || m_tdata[103:100] !== e.h ||
                    m_tdata[104] !== e.neg || m_tdata[112:105] !== e.val ||
                    m_tlast !== e.last)
                begin
                    $display("%0t: expected kind %0d corner %0d,%0d,%0d size %0dx%0d neg %0d id %0d last %0d",
                             $time, e.kind, $signed(e.cx), $signed(e.cy), $signed(e.cz),
                             e.w, e.h, e.neg, e.val, e.last);
                    $display("%0t: actual   kind %0d corner %0d,%0d,%0d size %0dx%0d neg %0d id %0d last %0d",
                             $time, m_tuser, $signed(m_tdata[31:0]), $signed(m_tdata[63:32]),
                             $signed(m_tdata[95:64]), m_tdata[99:96], m_tdata[103:100],
                             m_tdata[104], m_tdata[112:105], m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    task automatic test_edges();
        int a;
        send_command(vgm_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
        send_command(vgm_pkg::OP_MESH, 0, 0, 0, 0, vgm_pkg::AXIS_X, 0);
        send_command(vgm_pkg::OP_WRITE, 0, 0, 0, 8'hFF, 0, 0);
        send_command(vgm_pkg::OP_WRITE, 7, 7, 7, 8'h01, 0, 0);
        send_command(vgm_pkg::OP_WRITE, 8, 0, 0, 8'h55, 0, 0);
        send_command(vgm_pkg::OP_WRITE, 15, 15, 15, 8'hAA, 0, 0);
        send_command(vgm_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
        send_command(vgm_pkg::OP_READ, 7, 7, 7, 0, 0, 0);
        send_command(vgm_pkg::OP_READ, 8, 0, 0, 0, 0, 0);
        send_command(vgm_pkg::OP_READ, 0, 15, 0, 0, 0, 0);
        for (a = 0; a < 3; a++)
        begin
            send_command(vgm_pkg::OP_MESH, 0, 0, 0, 0, a[1:0], 0);
            send_command(vgm_pkg::OP_MESH, 0, 0, 0, 0, a[1:0], 8);
        end
        send_command(vgm_pkg::OP_MESH, 0, 0, 0, 0, vgm_pkg::AXIS_Y, 4);
        send_command(vgm_pkg::OP_MESH, 0, 0, 0, 0, vgm_pkg::AXIS_Z, 9);
        send_command(vgm_pkg::OP_MESH, 0, 0, 0, 0, vgm_pkg::AXIS_X, 15);
        send_command(vgm_pkg::OP_MESH, 0, 0, 0, 0, vgm_pkg::AXIS_NONE, 3);
        send_command(2'd3, 1, 2, 3, 8'h12, 0, 0);
        send_command(vgm_pkg::OP_WRITE, 7, 7, 7, 8'h00, 0, 0);
    endtask

    // Random mix of commands; writes favour a few ids so that neighbouring faces merge.
    task automatic test_random(int n_items);
        int k, r;
        logic [1:0] op;
        for (k = 0; k < n_items; k++)
        begin
            r = $urandom_range(99);
            if (r < 55)
                send_command(vgm_pkg::OP_WRITE,
                             4'(($urandom_range(9) < 8) ? $urandom_range(7) : $urandom()),
                             4'(($urandom_range(9) < 8) ? $urandom_range(7) : $urandom()),
                             4'(($urandom_range(9) < 8) ? $urandom_range(7) : $urandom()),
                             8'(($urandom_range(2) == 0) ? 0 :
                                (($urandom_range(3) == 0) ? $urandom() :
                                                            $urandom_range(1, 3))),
                             2'($urandom()), 4'($urandom()));
            else if (r < 72)
                send_command(vgm_pkg::OP_READ, 4'($urandom()), 4'($urandom()),
                             4'($urandom()), 8'($urandom()), 2'($urandom()),
                             4'($urandom()));
            else if (r < 97)
                send_command(vgm_pkg::OP_MESH, 4'($urandom()), 4'($urandom()),
                             4'($urandom()), 8'($urandom()),
                             ($urandom_range(9) == 0) ? vgm_pkg::AXIS_NONE
                                                      : 2'($urandom_range(2)),
                             4'(($urandom_range(9) == 0) ? $urandom() : $urandom_range(8)));
            else
            begin
                op = 2'd3;
                send_command(op, 4'($urandom()), 4'($urandom()), 4'($urandom()),
                             8'($urandom()), 2'($urandom()), 4'($urandom()));
            end
        end
    endtask

    task automatic test_origins(logic [30:0] vx, logic [30:0] vy, logic [30:0] vz);
        wait_drained();
        write_origin(vgm_pkg::REG_ORIGIN_X, vx);
        write_origin(vgm_pkg::REG_ORIGIN_Y, vy);
        write_origin(vgm_pkg::REG_ORIGIN_Z, vz);
        cfg_we <= 1'b0;
        send_command(vgm_pkg::OP_MESH, 0, 0, 0, 0, vgm_pkg::AXIS_X, 0);
        send_command(vgm_pkg::OP_MESH, 0, 0, 0, 0, vgm_pkg::AXIS_Z, 8);
    endtask

    initial
    begin
        int i;
        errors = 0;
        send_idle = 22;
        recv_idle = 62;
        for (i = 0; i < vgm_pkg::SDEPTH; i++) chunk[i] = 8'd0;
        for (i = 0; i < 3; i++) org[i] = 32'd0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_tready = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_edges();
        test_origins(31'h3FFF_FFFF, 31'h4000_0000, 31'd5);
        test_random(100);
        send_idle = 62;
        recv_idle = 22;
        test_origins(31'h4000_0000, 31'h3FFF_FFF9, 31'h7FFF_FFFF);
        test_random(100);
        // Hold the sender back until every outstanding result has been taken.
        wait_drained();
        send_idle = 0;
        recv_idle = 0;
        test_origins(31'd0, 31'd0, 31'd0);
        test_random(100);
        wait_drained();
        repeat (1000) @(negedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
